// ----- rtl/lps_pkg.sv -----
// Shared widths, command codes and constants of the LED pattern sequencer.
`timescale 1ns / 1ps

package lps_pkg;

    localparam int CMD_W    = 2;
    localparam int DATA_W   = 10;
    localparam int LED_W    = 8;
    localparam int MODE_W   = 3;
    localparam int PERIOD_W = 6;
    localparam int PHASE_W  = 3;

    // Input item kinds
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHAR   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BUTTON = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ADC    = 2'd3;

    // Pattern modes
    localparam logic [MODE_W-1:0] MODE_UP     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DOWN   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BOUNCE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RIDER  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd4;

    // Command characters
    localparam logic [DATA_W-1:0] CHAR_R = 10'd114;
    localparam logic [DATA_W-1:0] CHAR_L = 10'd108;
    localparam logic [DATA_W-1:0] CHAR_V = 10'd118;
    localparam logic [DATA_W-1:0] CHAR_S = 10'd115;
    localparam logic [DATA_W-1:0] CHAR_N = 10'd110;
    localparam logic [DATA_W-1:0] CHAR_T = 10'd116;

    // ADC thresholds, one bit wider than the reading
    localparam logic [DATA_W:0] ADC_LIM_0 = 11'd200;
    localparam logic [DATA_W:0] ADC_LIM_1 = 11'd500;
    localparam logic [DATA_W:0] ADC_LIM_2 = 11'd700;
    localparam logic [DATA_W:0] ADC_LIM_3 = 11'd900;
    localparam logic [DATA_W:0] ADC_LIM_4 = 11'd1120;

    // Step periods in ticks
    localparam logic [PERIOD_W-1:0] PERIOD_0     = 6'd10;
    localparam logic [PERIOD_W-1:0] PERIOD_1     = 6'd20;
    localparam logic [PERIOD_W-1:0] PERIOD_2     = 6'd30;
    localparam logic [PERIOD_W-1:0] PERIOD_3     = 6'd40;
    localparam logic [PERIOD_W-1:0] PERIOD_4     = 6'd60;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 6'd1;

    // Pattern bytes
    localparam logic [LED_W-1:0] BIT_LOW  = 8'h01;
    localparam logic [LED_W-1:0] BIT_HIGH = 8'h80;

    // Rider phases
    localparam logic [PHASE_W-1:0] RIDER_TURN = 3'd3;
    localparam logic [PHASE_W-1:0] RIDER_LAST = 3'd6;

endpackage

// ----- rtl/lps_if.sv -----
// Valid/ready channel interfaces for input items and results.
`timescale 1ns / 1ps

interface lps_item_if
    import lps_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] data_value;
    logic              button_level;

    modport source (output valid, output cmd, output data_value, output button_level,
                    input ready);
    modport sink   (input valid, input cmd, input data_value, input button_level,
                    output ready);
endinterface

interface lps_result_if
    import lps_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [LED_W-1:0] led_pattern;
    logic             led_update;
    logic             command_accepted;

    modport source (output valid, output led_pattern, output led_update,
                    output command_accepted, input ready);
    modport sink   (input valid, input led_pattern, input led_update,
                    input command_accepted, output ready);
endinterface

// ----- rtl/led_pattern_sequencer_core.sv -----
// LED pattern sequencer: input register, single-pass update logic and result register.
`timescale 1ns / 1ps

// Takes one item per clock cycle while the result side does not stall, and returns
// one result per item through the input register and then the result register.
// The pattern, mode, period and tick state is updated in the cycle an item leaves
// the input register, so back-to-back items see each other's effects in order. A
// stalled result holds the input register, and the input stays ready while that
// register is empty or moves on in the same cycle.
module led_pattern_sequencer_core
    import lps_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lps_item_if.sink      item,
    lps_result_if.source  result
);

    // Input register
    logic              in_valid_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [DATA_W-1:0] data_reg;
    logic              level_reg;

    // Sequencer state
    logic [LED_W-1:0]    walking_bit_reg,  walking_bit_next;
    logic                bounce_dir_reg,   bounce_dir_next;
    logic [LED_W-1:0]    rider_low_reg,    rider_low_next;
    logic [LED_W-1:0]    rider_high_reg,   rider_high_next;
    logic [PHASE_W-1:0]  rider_phase_reg,  rider_phase_next;
    logic [MODE_W-1:0]   pattern_mode_reg, pattern_mode_next;
    logic                invert_off_reg,   invert_off_next;
    logic                button_down_reg,  button_down_next;
    logic [PERIOD_W-1:0] step_period_reg,  step_period_next;
    logic [LED_W-1:0]    tick_count_reg,   tick_count_next;
    logic [LED_W-1:0]    last_leds_reg,    last_leds_next;

    // Result register
    logic             out_valid_reg;
    logic [LED_W-1:0] led_pattern_reg;
    logic             led_update_reg;
    logic             command_accepted_reg;

    logic             advance;
    logic             process;
    logic             update_next;
    logic             accepted_next;
    logic             step_fire;

    // Move the input register on when the result register is free or drains
    assign advance    = !out_valid_reg || result.ready;
    assign process    = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;

    assign result.valid            = out_valid_reg;
    assign result.led_pattern      = led_pattern_reg;
    assign result.led_update       = led_update_reg;
    assign result.command_accepted = command_accepted_reg;

    // Work out the next state and the result of the item in the input register
    always_comb
    begin
        logic [LED_W-1:0] tick_inc;
        logic [LED_W-1:0] shown;
        logic [LED_W-1:0] wb;
        logic             pressed;
        logic [DATA_W:0]  adc;

        walking_bit_next  = walking_bit_reg;
        bounce_dir_next   = bounce_dir_reg;
        rider_low_next    = rider_low_reg;
        rider_high_next   = rider_high_reg;
        rider_phase_next  = rider_phase_reg;
        pattern_mode_next = pattern_mode_reg;
        invert_off_next   = invert_off_reg;
        button_down_next  = button_down_reg;
        step_period_next  = step_period_reg;
        tick_count_next   = tick_count_reg;
        last_leds_next    = last_leds_reg;
        update_next       = 1'b0;
        accepted_next     = 1'b0;
        step_fire         = 1'b0;
        tick_inc          = tick_count_reg + 8'd1;
        shown             = walking_bit_reg;
        wb                = walking_bit_reg;
        pressed           = 1'b0;
        adc               = {1'b0, data_reg};

        case (cmd_reg)
            CMD_TICK:
            begin
                tick_count_next = tick_inc;
                if (tick_inc == {{(LED_W-PERIOD_W){1'b0}}, step_period_reg})
                begin
                    tick_count_next = '0;
                    step_fire       = 1'b1;
                    update_next     = 1'b1;
                    case (pattern_mode_reg)
                        MODE_UP:
                        begin
                            shown            = walking_bit_reg;
                            walking_bit_next = (walking_bit_reg == BIT_HIGH) ? BIT_LOW
                                               : {walking_bit_reg[LED_W-2:0], 1'b0};
                        end
                        MODE_DOWN:
                        begin
                            shown            = walking_bit_reg;
                            walking_bit_next = (walking_bit_reg == BIT_LOW) ? BIT_HIGH
                                               : {1'b0, walking_bit_reg[LED_W-1:1]};
                        end
                        MODE_BOUNCE:
                        begin
                            shown = walking_bit_reg;
                            if (!bounce_dir_reg)
                            begin
                                // Climb; the top bit turns round and shows again
                                if (walking_bit_reg == BIT_HIGH)
                                begin
                                    wb              = BIT_LOW;
                                    bounce_dir_next = 1'b1;
                                end
                                else
                                begin
                                    wb              = {walking_bit_reg[LED_W-2:0], 1'b0};
                                    bounce_dir_next = 1'b0;
                                end
                                walking_bit_next = (wb == BIT_LOW) ? BIT_HIGH : wb;
                            end
                            else
                            begin
                                // Descend; the bottom bit turns round and shows again
                                if (walking_bit_reg == BIT_LOW)
                                begin
                                    wb              = BIT_HIGH;
                                    bounce_dir_next = 1'b0;
                                end
                                else
                                begin
                                    wb              = {1'b0, walking_bit_reg[LED_W-1:1]};
                                    bounce_dir_next = 1'b1;
                                end
                                walking_bit_next = (wb == BIT_HIGH) ? BIT_LOW : wb;
                            end
                        end
                        MODE_RIDER:
                        begin
                            shown = rider_low_reg | rider_high_reg;
                            if (rider_phase_reg < RIDER_TURN)
                            begin
                                rider_low_next   = {rider_low_reg[LED_W-2:0], 1'b0};
                                rider_high_next  = {1'b0, rider_high_reg[LED_W-1:1]};
                                rider_phase_next = rider_phase_reg + 3'd1;
                            end
                            else if (rider_phase_reg < RIDER_LAST)
                            begin
                                rider_low_next   = {1'b0, rider_low_reg[LED_W-1:1]};
                                rider_high_next  = {rider_high_reg[LED_W-2:0], 1'b0};
                                rider_phase_next = rider_phase_reg + 3'd1;
                            end
                            else
                            begin
                                rider_phase_next = '0;
                                rider_low_next   = BIT_LOW;
                                rider_high_next  = BIT_HIGH;
                            end
                        end
                        default:
                        begin
                            // Out-of-range mode: drop back to the first pattern, no step
                            update_next       = 1'b0;
                            pattern_mode_next = MODE_UP;
                        end
                    endcase
                    if (update_next)
                        last_leds_next = invert_off_reg ? shown : ~shown;
                end
            end
            CMD_CHAR:
            begin
                accepted_next = 1'b1;
                case (data_reg)
                    CHAR_R:  pattern_mode_next = MODE_UP;
                    CHAR_L:  pattern_mode_next = MODE_DOWN;
                    CHAR_V:  pattern_mode_next = MODE_BOUNCE;
                    CHAR_S:  pattern_mode_next = MODE_RIDER;
                    CHAR_N:  invert_off_next   = 1'b0;
                    CHAR_T:  invert_off_next   = 1'b1;
                    default: accepted_next     = 1'b0;
                endcase
            end
            CMD_BUTTON:
            begin
                // Count a press on the release that follows it
                if (!button_down_reg)
                begin
                    if (!level_reg)
                        button_down_next = 1'b1;
                end
                else if (level_reg)
                begin
                    button_down_next = 1'b0;
                    pressed          = 1'b1;
                end
                if (pressed)
                    pattern_mode_next = pattern_mode_reg + 3'd1;
                else if (pattern_mode_reg == MODE_OFF)
                    pattern_mode_next = MODE_UP;
            end
            CMD_ADC:
            begin
                if (adc <= ADC_LIM_0)
                    step_period_next = PERIOD_0;
                else if (adc <= ADC_LIM_1)
                    step_period_next = PERIOD_1;
                else if (adc <= ADC_LIM_2)
                    step_period_next = PERIOD_2;
                else if (adc <= ADC_LIM_3)
                    step_period_next = PERIOD_3;
                else if (adc <= ADC_LIM_4)
                    step_period_next = PERIOD_4;
            end
            default:
            begin
                step_fire = 1'b0;
            end
        endcase
    end

    // Hold state, the input register and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            walking_bit_reg  <= BIT_LOW;
            bounce_dir_reg   <= 1'b0;
            rider_low_reg    <= BIT_LOW;
            rider_high_reg   <= BIT_HIGH;
            rider_phase_reg  <= '0;
            pattern_mode_reg <= MODE_UP;
            invert_off_reg   <= 1'b0;
            button_down_reg  <= 1'b0;
            step_period_reg  <= PERIOD_RESET;
            tick_count_reg   <= '0;
            last_leds_reg    <= '0;
        end
        else
        begin
            // Load the next transfer when the input register is free
            if (item.ready)
                in_valid_reg <= item.valid;

            // Drain or refill the result register
            if (advance)
                out_valid_reg <= in_valid_reg;

            if (process)
            begin
                walking_bit_reg  <= walking_bit_next;
                bounce_dir_reg   <= bounce_dir_next;
                rider_low_reg    <= rider_low_next;
                rider_high_reg   <= rider_high_next;
                rider_phase_reg  <= rider_phase_next;
                pattern_mode_reg <= pattern_mode_next;
                invert_off_reg   <= invert_off_next;
                button_down_reg  <= button_down_next;
                step_period_reg  <= step_period_next;
                tick_count_reg   <= tick_count_next;
                last_leds_reg    <= last_leds_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            cmd_reg   <= item.cmd;
            data_reg  <= item.data_value;
            level_reg <= item.button_level;
        end
        if (process)
        begin
            led_pattern_reg      <= last_leds_next;
            led_update_reg       <= update_next;
            command_accepted_reg <= accepted_next;
        end
    end

    // A step and an accepted character never come from the same item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(led_update_reg && command_accepted_reg))
        else $error("step and accepted character in one result");

    // A full input register waits while the result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !result.ready) |-> !item.ready)
        else $error("input taken while result stalled");

    // A pattern step clears the tick counter
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && step_fire) |=> (tick_count_reg == '0))
        else $error("tick counter not cleared after step");

    // The walking bit always has exactly one bit set
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(walking_bit_reg))
        else $error("walking bit lost its single set bit");

    // The rider phase never passes its last phase
    assert property (@(posedge clk) disable iff (!rst_n)
        rider_phase_reg <= RIDER_LAST)
        else $error("rider phase out of range");

endmodule

// ----- bench/lps_led_checker.sv -----
// Checker for the LED pattern sequencer: predicts every result and compares each transfer.
`timescale 1ns / 1ps

module lps_led_checker
    import lps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lps_item_if        item_mon,
    lps_result_if      result_mon,
    output int         mismatch_count,
    output int         awaiting,
    output int         step_count,
    output int         char_count,
    output int         result_count,
    output logic [7:0] step_mode_mask
);

    typedef struct packed {
        logic [LED_W-1:0] leds;
        logic             update;
        logic             accepted;
    } led_result_t;

    // Predicted sequencer state
    logic [LED_W-1:0]    walking_bit;
    logic                bounce_dir;
    logic [LED_W-1:0]    rider_low;
    logic [LED_W-1:0]    rider_high;
    logic [PHASE_W-1:0]  rider_phase;
    logic [MODE_W-1:0]   pattern_mode;
    logic                invert_off;
    logic                button_down;
    logic [PERIOD_W-1:0] step_period;
    logic [7:0]          tick_count;
    logic [LED_W-1:0]    last_leds;

    led_result_t expected_leds_q[$];
    int          errs;
    int          steps;
    int          chars;
    int          results;
    logic [7:0]  modes_stepped;

    // Latch a pattern byte onto the LEDs, complemented unless inversion is off
    function automatic void show_leds(input logic [LED_W-1:0] pattern);
        last_leds = invert_off ? pattern : ~pattern;
    endfunction

    // Show the walking bit and move it up; flag a wrap from the top end
    function automatic logic walk_up();
        show_leds(walking_bit);
        if (walking_bit == BIT_HIGH)
        begin
            walking_bit = BIT_LOW;
            return 1'b1;
        end
        walking_bit = walking_bit << 1;
        return 1'b0;
    endfunction

    // Show the walking bit and move it down; clear the flag on a wrap from the bottom
    function automatic logic walk_down();
        show_leds(walking_bit);
        if (walking_bit == BIT_LOW)
        begin
            walking_bit = BIT_HIGH;
            return 1'b0;
        end
        walking_bit = walking_bit >> 1;
        return 1'b1;
    endfunction

    function automatic led_result_t predict_leds(input logic [CMD_W-1:0]  cmd,
                                                 input logic [DATA_W-1:0] data,
                                                 input logic              level);
        led_result_t res;
        logic        pressed;
        res     = '0;
        pressed = 1'b0;
        case (cmd)
            CMD_TICK:
            begin
                // Count the tick; the 8-bit counter wraps if it has passed the period
                tick_count = tick_count + 8'd1;
                if (tick_count == {2'b00, step_period})
                begin
                    tick_count = '0;
                    modes_stepped[pattern_mode] = 1'b1;
                    res.update = 1'b1;
                    case (pattern_mode)
                        MODE_UP:   void'(walk_up());
                        MODE_DOWN: void'(walk_down());
                        MODE_BOUNCE:
                        begin
                            // Each end bit shows twice, once per direction
                            if (!bounce_dir)
                            begin
                                bounce_dir = walk_up();
                                if (walking_bit == BIT_LOW)
                                    walking_bit = BIT_HIGH;
                            end
                            else
                            begin
                                bounce_dir = walk_down();
                                if (walking_bit == BIT_HIGH)
                                    walking_bit = BIT_LOW;
                            end
                        end
                        MODE_RIDER:
                        begin
                            // Close in, open out, then repeat the outer pair
                            show_leds(rider_low | rider_high);
                            if (rider_phase < RIDER_TURN)
                            begin
                                rider_low   = rider_low << 1;
                                rider_high  = rider_high >> 1;
                                rider_phase = rider_phase + 1'b1;
                            end
                            else if (rider_phase < RIDER_LAST)
                            begin
                                rider_low   = rider_low >> 1;
                                rider_high  = rider_high << 1;
                                rider_phase = rider_phase + 1'b1;
                            end
                            else
                            begin
                                rider_phase = '0;
                                rider_low   = BIT_LOW;
                                rider_high  = BIT_HIGH;
                            end
                        end
                        default:
                        begin
                            // Out-of-range mode: no write, fall back to rotate up
                            pattern_mode = MODE_UP;
                            res.update   = 1'b0;
                        end
                    endcase
                end
            end
            CMD_CHAR:
            begin
                res.accepted = 1'b1;
                case (data)
                    CHAR_R:  pattern_mode = MODE_UP;
                    CHAR_L:  pattern_mode = MODE_DOWN;
                    CHAR_V:  pattern_mode = MODE_BOUNCE;
                    CHAR_S:  pattern_mode = MODE_RIDER;
                    CHAR_N:  invert_off = 1'b0;
                    CHAR_T:  invert_off = 1'b1;
                    default: res.accepted = 1'b0;
                endcase
            end
            CMD_BUTTON:
            begin
                // A press followed by a release advances the mode
                if (!button_down)
                begin
                    if (!level)
                        button_down = 1'b1;
                end
                else if (level)
                begin
                    button_down = 1'b0;
                    pressed     = 1'b1;
                end
                if (pressed)
                    pattern_mode = pattern_mode + 1'b1;
                else if (pattern_mode == MODE_OFF)
                    pattern_mode = MODE_UP;
            end
            default:
            begin
                // Map the reading onto a step period; above the top band keep it
                if ({1'b0, data} <= ADC_LIM_0)
                    step_period = PERIOD_0;
                else if ({1'b0, data} <= ADC_LIM_1)
                    step_period = PERIOD_1;
                else if ({1'b0, data} <= ADC_LIM_2)
                    step_period = PERIOD_2;
                else if ({1'b0, data} <= ADC_LIM_3)
                    step_period = PERIOD_3;
                else if ({1'b0, data} <= ADC_LIM_4)
                    step_period = PERIOD_4;
            end
        endcase
        res.leds = last_leds;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        led_result_t got;
        led_result_t want;
        if (!rst_n)
        begin
            walking_bit   = BIT_LOW;
            bounce_dir    = 1'b0;
            rider_low     = BIT_LOW;
            rider_high    = BIT_HIGH;
            rider_phase   = '0;
            pattern_mode  = MODE_UP;
            invert_off    = 1'b0;
            button_down   = 1'b0;
            step_period   = PERIOD_RESET;
            tick_count    = '0;
            last_leds     = '0;
            expected_leds_q.delete();
            errs          = 0;
            steps         = 0;
            chars         = 0;
            results       = 0;
            modes_stepped = '0;
        end
        else
        begin
            // Predict the result of each input transfer
            if (item_mon.valid && item_mon.ready)
            begin
                want = predict_leds(item_mon.cmd, item_mon.data_value, item_mon.button_level);
                expected_leds_q.push_back(want);
                if (want.update)
                    steps++;
                if (want.accepted)
                    chars++;
            end
            // Compare each result transfer with the oldest prediction
            if (result_mon.valid && result_mon.ready)
            begin
                got.leds     = result_mon.led_pattern;
                got.update   = result_mon.led_update;
                got.accepted = result_mon.command_accepted;
                results++;
                if (expected_leds_q.size() == 0)
                begin
                    errs++;
                    $display("%0t: result with none expected: led_pattern %h update %b accepted %b",
                             $time, got.leds, got.update, got.accepted);
                end
                else
                begin
                    want = expected_leds_q.pop_front();
                    if (got.leds !== want.leds)
                    begin
                        errs++;
                        $display("%0t: led_pattern expected %h got %h", $time, want.leds, got.leds);
                    end
                    if (got.update !== want.update)
                    begin
                        errs++;
                        $display("%0t: led_update expected %b got %b", $time, want.update,
                                 got.update);
                    end
                    if (got.accepted !== want.accepted)
                    begin
                        errs++;
                        $display("%0t: command_accepted expected %b got %b", $time,
                                 want.accepted, got.accepted);
                    end
                end
            end
        end
        mismatch_count <= errs;
        awaiting       <= expected_leds_q.size();
        step_count     <= steps;
        char_count     <= chars;
        result_count   <= results;
        step_mode_mask <= modes_stepped;
    end

endmodule

// ----- bench/tb_led_pattern_sequencer_core.sv -----
// Testbench top for the LED pattern sequencer: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_led_pattern_sequencer_core;
    import lps_pkg::*;

    localparam int RANDOM_ITEMS  = 900;
    localparam int DIRECTED_MAX  = 25;
    localparam int HOLD_CYCLES   = 64;
    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 10;

    localparam logic [DATA_W-1:0] KNOWN_CHARS [6] = '{CHAR_R, CHAR_L, CHAR_V, CHAR_S,
                                                      CHAR_N, CHAR_T};

    typedef enum int {STALL_NONE, STALL_HALF, STALL_RARE, STALL_EVERY_THIRD} stall_kind_t;

    logic clk;
    logic rst_n;

    lps_item_if   item_ch ();
    lps_result_if result_ch ();

    int         mismatch_count;
    int         awaiting;
    int         step_count;
    int         char_count;
    int         result_count;
    logic [7:0] step_mode_mask;

    int items_sent   = 0;
    int burst_left   = 0;
    int holds_asked  = 0;
    int holds_served = 0;

    led_pattern_sequencer_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    lps_led_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_mon       (item_ch),
        .result_mon     (result_ch),
        .mismatch_count (mismatch_count),
        .awaiting       (awaiting),
        .step_count     (step_count),
        .char_count     (char_count),
        .result_count   (result_count),
        .step_mode_mask (step_mode_mask)
    );

    initial clk = 1'b0;

    always #4 clk = ~clk;

    // Watchdog: end the run after too long without any transfer
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Result side: stretches of differing stall patterns, plus long hold-offs on request
    initial
    begin
        stall_kind_t kind;
        int          len;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holds_served < holds_asked)
            begin
                // Hold off so the block fills and stalls its input
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_served++;
            end
            else
            begin
                kind = stall_kind_t'($urandom_range(0, 3));
                len  = $urandom_range(4, 40);
                for (int i = 0; i < len; i++)
                begin
                    case (kind)
                        STALL_NONE: result_ch.ready <= 1'b1;
                        STALL_HALF: result_ch.ready <= 1'($urandom_range(0, 1));
                        STALL_RARE: result_ch.ready <= ($urandom_range(0, 5) != 0);
                        default:    result_ch.ready <= (i % 3 != 2);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Offer one item and hold it until the transfer; bursts are separated by random gaps
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] data,
                         input logic level);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 15) == 0)
                gap = 30;
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        item_ch.valid        <= 1'b1;
        item_ch.cmd          <= cmd;
        item_ch.data_value   <= data;
        item_ch.button_level <= level;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Stop offering until every predicted result has come back
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    // One random scene: mostly tick runs and well-formed button presses, some noise
    task automatic random_scene();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            // Tick run with the odd stray item mixed in
            n = $urandom_range(5, 60);
            repeat (n)
            begin
                if ($urandom_range(0, 19) == 0)
                    offer(CMD_W'($urandom), DATA_W'($urandom), 1'($urandom));
                else
                    offer(CMD_TICK, DATA_W'($urandom), 1'($urandom));
            end
        end
        else if (pick < 70)
        begin
            if ($urandom_range(0, 4) != 0)
                offer(CMD_CHAR, KNOWN_CHARS[$urandom_range(0, 5)], 1'($urandom));
            else
                offer(CMD_CHAR, DATA_W'($urandom), 1'($urandom));
        end
        else if (pick < 85)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                // Press, maybe held, then release
                repeat ($urandom_range(1, 3)) offer(CMD_BUTTON, DATA_W'($urandom), 1'b0);
                repeat ($urandom_range(1, 2)) offer(CMD_BUTTON, DATA_W'($urandom), 1'b1);
            end
            else
                repeat ($urandom_range(1, 3))
                    offer(CMD_BUTTON, DATA_W'($urandom), 1'($urandom));
        end
        else if (pick < 95)
        begin
            // Favour the shortest period so pattern steps come often
            if ($urandom_range(0, 2) != 0)
                offer(CMD_ADC, DATA_W'($urandom_range(0, 200)), 1'($urandom));
            else
                offer(CMD_ADC, DATA_W'($urandom), 1'($urandom));
        end
        else
            offer(CMD_W'($urandom), DATA_W'($urandom), 1'($urandom));
    endtask

    initial
    begin
        int scene;
        item_ch.valid        <= 1'b0;
        item_ch.cmd          <= CMD_TICK;
        item_ch.data_value   <= '0;
        item_ch.button_level <= 1'b1;
        rst_n                <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every pattern at the reset period, inversion, a press into the
        // out-of-range mode, unknown characters and the ADC band edges
        offer(CMD_TICK, '0, 1'b0);
        offer(CMD_TICK, '1, 1'b1);
        offer(CMD_CHAR, CHAR_T, 1'b1);
        offer(CMD_TICK, '0, 1'b0);
        offer(CMD_CHAR, CHAR_L, 1'b0);
        offer(CMD_TICK, '0, 1'b0);
        offer(CMD_CHAR, CHAR_V, 1'b0);
        offer(CMD_TICK, '0, 1'b0);
        offer(CMD_CHAR, CHAR_S, 1'b0);
        offer(CMD_TICK, '0, 1'b0);
        offer(CMD_BUTTON, '0, 1'b0);
        offer(CMD_BUTTON, '0, 1'b0);
        offer(CMD_BUTTON, '1, 1'b1);
        offer(CMD_TICK, '0, 1'b0);
        offer(CMD_TICK, '0, 1'b0);
        offer(CMD_CHAR, CHAR_N, 1'b0);
        offer(CMD_CHAR, '0, 1'b0);
        offer(CMD_CHAR, '1, 1'b1);
        offer(CMD_CHAR, CHAR_R, 1'b0);
        offer(CMD_ADC, DATA_W'(ADC_LIM_0), 1'b0);
        offer(CMD_ADC, DATA_W'(ADC_LIM_0 + 1), 1'b0);
        offer(CMD_ADC, DATA_W'(ADC_LIM_2), 1'b0);
        offer(CMD_ADC, DATA_W'(ADC_LIM_3), 1'b0);
        offer(CMD_ADC, '1, 1'b1);
        offer(CMD_ADC, '0, 1'b0);
        drain_results();

        // Random scenes, with long receiver hold-offs and full drains along the way
        scene = 0;
        while (items_sent < DIRECTED_MAX + RANDOM_ITEMS)
        begin
            if (scene == 3 || scene == 35)
                holds_asked++;
            if (scene % 30 == 12)
                drain_results();
            random_scene();
            scene++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run: %0d items, %0d results checked, %0d pattern steps, modes stepped %b,",
                 items_sent, result_count, step_count, step_mode_mask);
        $display("     %0d command characters taken, %0d receiver hold-offs.",
                 char_count, holds_served);
        if (awaiting != 0)
            $display("%0t: %0d expected results never arrived", $time, awaiting);
        if (mismatch_count == 0 && awaiting == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/lps_pkg.sv
rtl/lps_if.sv
rtl/led_pattern_sequencer_core.sv
bench/lps_led_checker.sv
bench/tb_led_pattern_sequencer_core.sv
